@@ rtl/core/assert_macros.svh @@
// assertion macros used by the port-level checker
// no dependencies; clk and rst_n must exist where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/pwc_pkg.sv @@
// shared types, constants and command/status structs of the pulse width clusterer
// no dependencies
package pwc_pkg;

    localparam int SLOT_COUNT    = 8;
    localparam int WIDTH_BITS    = 24;
    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = WIDTH_BITS + COUNT_BITS;
    localparam int SLOT_IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int USED_BITS     = $clog2(SLOT_COUNT + 1);
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS + 1);
    localparam int RANK_BITS     = 3;
    localparam int TOL_BITS      = 8;
    localparam int FLOOR_BITS    = 16;
    localparam int WANT_BITS     = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    // stream payload layout
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_FIELD_BITS = WIDTH_BITS + COUNT_BITS + RANK_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [USED_BITS-1:0]  SLOTS_FULL = USED_BITS'(SLOT_COUNT);

    // reset values of the configuration registers
    localparam logic [TOL_BITS-1:0]   TOL_RESET   = 8'd51;
    localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 16'd20;
    localparam logic [WANT_BITS-1:0]  WANT_RESET  = 4'd8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TOLERANCE = 2'd0,
        REG_FLOOR     = 2'd1,
        REG_WANTED    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] members;
        logic [WIDTH_BITS-1:0] centre;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_DIV,
        ST_REPORT,
        ST_ROW,
        ST_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic load_in;
        logic scan_step;
        logic place;
        logic div_step;
        logic div_write;
        logic sort_init;
        logic row_load;
        logic cmp_step;
        logic row_next;
        logic swap_a;
        logic swap_b;
        logic emit_init;
        logic emit_load;
        logic empty_load;
    } cmd_t;

    typedef struct packed {
        logic take;
        logic in_last;
        logic last;
        logic scan_done;
        logic place_new;
        logic div_done;
        logic used_zero;
        logic sort_done;
        logic cmp_done;
        logic swap_needed;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/core/pulse_width_clusterer.sv @@
// Pulse width clusterer. Input stream: tdata[23:0] signed timing, tlast marks
// the last sample of a capture. Each nonzero width is matched against up to
// eight slots (one slot per cycle), joins or opens a slot, and the joined
// slot's mean is recomputed by a bit-serial divider (40 steps and a write).
// A zero or dropped sample is taken in the idle state alone; a sample that
// opens a slot skips the divider, and one that joins a slot waits for it.
// On tlast the slots are selection-sorted by member count, largest first,
// and the first clusters_wanted (no more than the slots in use) are sent
// one transaction each on the output stream, tlast on the final one; an
// empty capture gives one transaction with members 0. Then the capture
// clears. The output register holds a result while the receiver stalls;
// the block accepts the next sample once the last result is in that
// register. Reset clears the capture and loads the configuration defaults
// (tolerance 51/256, floor 20, eight clusters). The user is to write
// configuration through cfg_we/cfg_index/cfg_data only while no
// transaction is in work; the block itself does not enforce it.
// Depends on pwc_pkg, pwc_ctrl and pwc_datapath.
module pulse_width_clusterer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pwc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [pwc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [pwc_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,  // timing
    input  logic                                  s_axis_tlast,  // end_of_capture
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // centre, members, rank, dropped, zero pad
    output logic [pwc_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast   // final_res
);
    import pwc_pkg::*;

    cmd_t    cmd;
    status_t st;

    // control state machine
    pwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .st       (st),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // datapath
    pwc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ rtl/core/pwc_ctrl.sv @@
// control state machine of the pulse width clusterer
// depends on pwc_pkg (state, command and status types)
module pwc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pwc_pkg::status_t st,
    output logic             in_ready,
    output pwc_pkg::cmd_t    cmd
);
    import pwc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (st.take)
                        state_next = ST_SCAN;
                    else if (st.in_last)
                        state_next = ST_REPORT;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                    state_next = ST_PLACE;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
                if (!st.place_new)
                    state_next = ST_DIV;
                else if (st.last)
                    state_next = ST_REPORT;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next = st.last ? ST_REPORT : ST_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (st.used_zero)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    cmd.sort_init = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (st.sort_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.row_load = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (!st.cmp_done)
                begin
                    cmd.cmp_step = 1'b1;
                end
                else if (st.swap_needed)
                begin
                    state_next = ST_SWAP_A;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                state_next = ST_ROW;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (st.emit_last)
                        state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.empty_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/pwc_datapath.sv @@
// datapath: slot store, nearest-slot scan, serial divider, sort and result register
// depends on pwc_pkg (slot type, command and status structs, constants)
module pwc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pwc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [pwc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic [pwc_pkg::IN_TDATA_BITS-1:0]     in_data,
    input  logic                                  in_last,
    input  pwc_pkg::cmd_t                         cmd,
    output pwc_pkg::status_t                      st,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pwc_pkg::OUT_TDATA_BITS-1:0]    out_data,
    output logic                                  out_last
);
    import pwc_pkg::*;

    // configuration
    logic [TOL_BITS-1:0]   tol_reg;
    logic [FLOOR_BITS-1:0] floor_reg;
    logic [WANT_BITS-1:0]  want_reg;

    // capture state
    slot_t                 slot_mem [SLOT_COUNT];
    logic [USED_BITS-1:0]  used_reg;
    logic [COUNT_BITS-1:0] samples_reg;
    logic                  overflow_reg;
    logic [WIDTH_BITS-1:0] w_reg;
    logic                  last_reg;

    // scan trackers
    logic [USED_BITS-1:0]     scan_idx_reg;
    logic                     match_found_reg;
    logic [WIDTH_BITS-1:0]    match_d_reg;
    logic [SLOT_IDX_BITS-1:0] match_idx_reg;
    logic                     near_found_reg;
    logic [WIDTH_BITS-1:0]    near_d_reg;
    logic [SLOT_IDX_BITS-1:0] near_idx_reg;
    logic [SLOT_IDX_BITS-1:0] target_reg;

    // divider
    logic [SUM_BITS-1:0]     quo_reg;
    logic [COUNT_BITS-1:0]   den_reg;
    logic [COUNT_BITS:0]     rem_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;

    // sort and emit
    logic [USED_BITS-1:0]     a_reg;
    logic [USED_BITS-1:0]     b_reg;
    logic [SLOT_IDX_BITS-1:0] m_reg;
    slot_t                    temp_reg;
    slot_t                    best_reg;
    logic [USED_BITS-1:0]     e_reg;

    // result register
    logic                      out_valid_reg;
    logic [WIDTH_BITS-1:0]     out_centre_reg;
    logic [COUNT_BITS-1:0]     out_members_reg;
    logic [RANK_BITS-1:0]      out_rank_reg;
    logic                      out_dropped_reg;
    logic                      out_last_reg;

    logic [WIDTH_BITS-1:0]      w_in;
    logic [SLOT_IDX_BITS-1:0]   rd_idx;
    slot_t                      rd_slot;
    logic [WIDTH_BITS+TOL_BITS-1:0] prod;
    logic [WIDTH_BITS-1:0]      tol_rel;
    logic [WIDTH_BITS-1:0]      tol;
    logic [WIDTH_BITS-1:0]      delta;
    logic                       in_tol;
    logic [SLOT_IDX_BITS-1:0]   place_idx;
    logic [SUM_BITS-1:0]        new_sum;
    logic [COUNT_BITS-1:0]      new_members;
    logic [COUNT_BITS:0]        trial;
    logic                       q_bit;
    logic [WANT_BITS-1:0]       want_eff;
    logic [USED_BITS-1:0]       k_count;
    logic                       out_clear;

    // width of the incoming timing
    assign w_in = in_data[IN_TDATA_BITS-1] ? (~in_data + 1'b1) : in_data;

    // single read address of the slot store
    always_comb
    begin
        priority if (cmd.scan_step)
            rd_idx = scan_idx_reg[SLOT_IDX_BITS-1:0];
        else if (cmd.place)
            rd_idx = place_idx;
        else if (cmd.row_load)
            rd_idx = a_reg[SLOT_IDX_BITS-1:0];
        else if (cmd.cmp_step)
            rd_idx = b_reg[SLOT_IDX_BITS-1:0];
        else
            rd_idx = e_reg[SLOT_IDX_BITS-1:0];
    end
    assign rd_slot = slot_mem[rd_idx];

    // tolerance and distance of the slot under scan
    assign prod    = tol_reg * rd_slot.centre;
    assign tol_rel = prod[WIDTH_BITS+TOL_BITS-1:TOL_BITS];
    assign tol     = (tol_rel < WIDTH_BITS'(floor_reg)) ? WIDTH_BITS'(floor_reg) : tol_rel;
    assign delta   = (w_reg >= rd_slot.centre) ? (w_reg - rd_slot.centre)
                                               : (rd_slot.centre - w_reg);
    assign in_tol  = (delta <= tol);

    // placement target and updated sums
    assign place_idx   = match_found_reg ? match_idx_reg : near_idx_reg;
    assign new_sum     = rd_slot.sum + SUM_BITS'(w_reg);
    assign new_members = rd_slot.members + 1'b1;

    // one restoring division step
    assign trial = {rem_reg[COUNT_BITS-1:0], quo_reg[SUM_BITS-1]};
    assign q_bit = (trial >= {1'b0, den_reg});

    // report length
    assign want_eff  = (want_reg == '0) ? WANT_BITS'(1) : want_reg;
    assign k_count   = (WANT_BITS'(used_reg) < want_eff) ? used_reg : USED_BITS'(want_eff);
    assign out_clear = (cmd.emit_load && st.emit_last) || cmd.empty_load;

    // status to the controller
    always_comb
    begin
        st             = '0;
        st.take        = (w_in != '0) && (samples_reg != COUNT_MAX);
        st.in_last     = in_last;
        st.last        = last_reg;
        st.scan_done   = (scan_idx_reg == used_reg);
        st.place_new   = !match_found_reg && (used_reg < SLOTS_FULL);
        st.div_done    = (div_cnt_reg == DIV_CNT_BITS'(SUM_BITS));
        st.used_zero   = (used_reg == '0);
        st.sort_done   = ((a_reg + 1'b1) >= used_reg);
        st.cmp_done    = (b_reg == used_reg);
        st.swap_needed = (m_reg != a_reg[SLOT_IDX_BITS-1:0]);
        st.emit_last   = ((e_reg + 1'b1) == k_count);
        st.out_free    = !out_valid_reg || out_ready;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            floor_reg <= FLOOR_RESET;
            want_reg  <= WANT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOLERANCE: tol_reg   <= cfg_data[TOL_BITS-1:0];
                REG_FLOOR:     floor_reg <= cfg_data[FLOOR_BITS-1:0];
                REG_WANTED:    want_reg  <= cfg_data[WANT_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // capture counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            samples_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else if (out_clear)
        begin
            used_reg     <= '0;
            samples_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in && (w_in != '0))
            begin
                if (samples_reg == COUNT_MAX)
                    overflow_reg <= 1'b1;
                else
                    samples_reg <= samples_reg + 1'b1;
            end
            if (cmd.place && st.place_new)
                used_reg <= used_reg + 1'b1;
        end
    end

    // slot store writes
    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            if (st.place_new)
            begin
                slot_mem[used_reg[SLOT_IDX_BITS-1:0]] <=
                    '{sum: SUM_BITS'(w_reg), members: COUNT_BITS'(1), centre: w_reg};
            end
            else
            begin
                slot_mem[place_idx].sum     <= new_sum;
                slot_mem[place_idx].members <= new_members;
            end
        end
        else if (cmd.div_write)
        begin
            slot_mem[target_reg].centre <= quo_reg[WIDTH_BITS-1:0];
        end
        else if (cmd.swap_a)
        begin
            slot_mem[a_reg[SLOT_IDX_BITS-1:0]] <= best_reg;
        end
        else if (cmd.swap_b)
        begin
            slot_mem[m_reg] <= temp_reg;
        end
    end

    // sample, scan, divider and sort working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            w_reg           <= w_in;
            last_reg        <= in_last;
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            near_found_reg  <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (in_tol && (!match_found_reg || (delta < match_d_reg)))
            begin
                match_found_reg <= 1'b1;
                match_d_reg     <= delta;
                match_idx_reg   <= rd_idx;
            end
            if (!near_found_reg || (delta < near_d_reg))
            begin
                near_found_reg <= 1'b1;
                near_d_reg     <= delta;
                near_idx_reg   <= rd_idx;
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.place)
        begin
            target_reg  <= place_idx;
            quo_reg     <= new_sum;
            den_reg     <= new_members;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= q_bit ? (trial - {1'b0, den_reg}) : trial;
            quo_reg     <= {quo_reg[SUM_BITS-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.sort_init)
            a_reg <= '0;
        if (cmd.row_load)
        begin
            temp_reg <= rd_slot;
            best_reg <= rd_slot;
            m_reg    <= a_reg[SLOT_IDX_BITS-1:0];
            b_reg    <= a_reg + 1'b1;
        end
        if (cmd.cmp_step)
        begin
            if (rd_slot.members > best_reg.members)
            begin
                best_reg <= rd_slot;
                m_reg    <= rd_idx;
            end
            b_reg <= b_reg + 1'b1;
        end
        if (cmd.row_next || cmd.swap_b)
            a_reg <= a_reg + 1'b1;
        if (cmd.emit_init)
            e_reg <= '0;
        else if (cmd.emit_load)
            e_reg <= e_reg + 1'b1;
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.empty_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_centre_reg  <= rd_slot.centre;
            out_members_reg <= rd_slot.members;
            out_rank_reg    <= RANK_BITS'(e_reg);
            out_dropped_reg <= overflow_reg;
            out_last_reg    <= st.emit_last;
        end
        else if (cmd.empty_load)
        begin
            out_centre_reg  <= '0;
            out_members_reg <= '0;
            out_rank_reg    <= '0;
            out_dropped_reg <= overflow_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = OUT_TDATA_BITS'({out_dropped_reg, out_rank_reg,
                                        out_members_reg, out_centre_reg});

endmodule

@@ rtl/core/pwc_checker.sv @@
// port-level checker for the pulse width clusterer, bound to the top level
// depends on pwc_pkg and assert_macros.svh
`include "assert_macros.svh"

module pwc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  s_axis_tlast,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [pwc_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    input logic                                  m_axis_tlast
);
    import pwc_pkg::*;

    // a stalled result holds still
    `ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "result changed while stalled")

    // a capture end always starts a report, so input closes
    `ASSERT_CLK(a_last_busy, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "input open right after capture end")

    // an empty cluster only appears as the single final result
    `ASSERT_CLK(a_empty_final, (m_axis_tvalid && (m_axis_tdata[WIDTH_BITS +: COUNT_BITS] == '0)) |-> m_axis_tlast, "empty cluster not final")

    // a pending result that is not the last keeps the input closed
    `ASSERT_CLK(a_report_busy, (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "input open during a report")

endmodule

bind pulse_width_clusterer pwc_checker u_pwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
